// ===== hdl/running_mean_variance_accumulator_top_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef RUNNING_MEAN_VARIANCE_ACCUMULATOR_TOP_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication
`define RMVA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMVA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rmva_pkg.sv =====
package rmva_pkg;

    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = 6;

    typedef struct packed {
        logic [3:0]  channel;
        logic [31:0] sample;
        logic [31:0] step_count;
    } in_t;

    typedef struct packed {
        logic [3:0]  channel_out;
        logic [31:0] mean;
        logic [63:0] variance_accum;
        logic        error;
    } out_t;

    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] mean;
        logic [63:0] var_accum;
    } row_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_DIFF = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_TERM = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic diff_en;
        logic mul_en;
        logic div_step;
        logic term_en;
        logic fin_en;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic out_busy;
    } status_t;

endpackage

// ===== hdl/rmva_ram.sv =====
module rmva_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rmva_div.sv =====
module rmva_div (
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        rem_nz
);

    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // restoring division, one quotient bit per beat of step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[63]};
        diff     = shifted - {1'b0, divisor};
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

// ===== hdl/rmva_datapath.sv =====
module rmva_datapath #(
    parameter int CHANNELS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rmva_pkg::in_t    in_data,
    input  logic             out_ready,
    output logic             out_valid,
    output rmva_pkg::out_t   out_data,
    input  rmva_pkg::cmd_t   cmd,
    output rmva_pkg::status_t status
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    rmva_pkg::in_t   item_reg;
    logic            ch_ok_reg;
    logic            rd_valid_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic [CH_W-1:0] addr;

    logic [31:0]     mean_old_reg;
    logic [63:0]     var_old_reg;
    logic [63:0]     sum_new_reg;
    logic [31:0]     ad_reg;
    logic [63:0]     d2_reg;
    logic [63:0]     term_reg;

    logic            out_valid_reg;
    rmva_pkg::out_t  out_data_reg, out_data_next;

    rmva_pkg::row_t  rd_row, cur_row, wr_row;
    logic [64:0]     sum_ext;
    logic [64:0]     var_ext;
    logic [63:0]     var_new;
    logic [31:0]     mean_new;
    logic [63:0]     d2;
    logic [63:0]     quo_a, quo_b;
    logic            rnz_a, rnz_b;
    logic            n_zero;
    logic            wr_en;

    assign addr   = CH_W'(item_reg.channel);
    assign n_zero = (item_reg.step_count == '0);

    assign status.skip     = !ch_ok_reg || n_zero;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            item_reg  <= in_data;
            ch_ok_reg <= (32'(in_data.channel) < 32'(CHANNELS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_valid_reg <= ch_ok_reg && valid_reg[addr];
            end
            if (wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    rmva_ram #(
        .WIDTH ($bits(rmva_pkg::row_t)),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr),
        .wdata (wr_row),
        .re    (cmd.rd_en),
        .raddr (addr),
        .rdata (rd_row)
    );

    // unwritten channels read as zero
    assign cur_row = rd_valid_reg ? rd_row : '0;
    assign sum_ext = {1'b0, cur_row.sum} + {33'd0, item_reg.sample};

    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            mean_old_reg <= cur_row.mean;
            var_old_reg  <= cur_row.var_accum;
            sum_new_reg  <= sum_ext[64] ? '1 : sum_ext[63:0];
            ad_reg       <= (item_reg.sample >= cur_row.mean) ?
                            (item_reg.sample - cur_row.mean) :
                            (cur_row.mean - item_reg.sample);
        end
    end

    assign d2 = {32'd0, ad_reg} * {32'd0, ad_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            d2_reg <= d2;
        end
        if (cmd.term_en)
        begin
            term_reg <= d2_reg - (quo_a + {63'd0, rnz_a});
        end
    end

    rmva_div u_div_var (
        .clk      (clk),
        .load     (cmd.mul_en),
        .step     (cmd.div_step),
        .dividend (d2),
        .divisor  (item_reg.step_count),
        .quotient (quo_a),
        .rem_nz   (rnz_a)
    );

    rmva_div u_div_mean (
        .clk      (clk),
        .load     (cmd.mul_en),
        .step     (cmd.div_step),
        .dividend (sum_new_reg),
        .divisor  (item_reg.step_count),
        .quotient (quo_b),
        .rem_nz   (rnz_b)
    );

    assign var_ext  = {1'b0, var_old_reg} + {1'b0, term_reg};
    assign var_new  = var_ext[64] ? '1 : var_ext[63:0];
    assign mean_new = (|quo_b[63:32]) ? '1 : quo_b[31:0];

    assign wr_en            = cmd.fin_en && !status.skip;
    assign wr_row.sum       = sum_new_reg;
    assign wr_row.mean      = mean_new;
    assign wr_row.var_accum = var_new;

    always_comb
    begin
        out_data_next.channel_out = item_reg.channel;
        if (!ch_ok_reg)
        begin
            out_data_next.mean           = '0;
            out_data_next.variance_accum = '0;
            out_data_next.error          = 1'b0;
        end
        else if (n_zero)
        begin
            out_data_next.mean           = mean_old_reg;
            out_data_next.variance_accum = var_old_reg;
            out_data_next.error          = 1'b1;
        end
        else
        begin
            out_data_next.mean           = mean_new;
            out_data_next.variance_accum = var_new;
            out_data_next.error          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // remainder of the mean division is not needed
    logic unused_rnz;
    assign unused_rnz = rnz_b;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/rmva_ctrl.sv =====
module rmva_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rmva_pkg::status_t status,
    output rmva_pkg::cmd_t    cmd
);

    rmva_pkg::state_t           state_reg, state_next;
    logic [rmva_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rmva_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = rmva_pkg::S_READ;
                end
            end
            rmva_pkg::S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = rmva_pkg::S_DIFF;
            end
            rmva_pkg::S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = status.skip ? rmva_pkg::S_FIN : rmva_pkg::S_MUL;
            end
            rmva_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = '0;
                state_next = rmva_pkg::S_DIV;
            end
            rmva_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == rmva_pkg::CNT_W'(rmva_pkg::DIV_STEPS - 1))
                begin
                    state_next = rmva_pkg::S_TERM;
                end
            end
            rmva_pkg::S_TERM:
            begin
                cmd.term_en = 1'b1;
                state_next  = rmva_pkg::S_FIN;
            end
            rmva_pkg::S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.fin_en = 1'b1;
                    state_next = rmva_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rmva_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmva_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/running_mean_variance_accumulator_top.sv =====
// Items pass READ, DIFF, MUL, DIV, TERM and FIN; if step_count is zero or the
// channel is out of range, DIFF goes straight to FIN. FIN waits while the output
// is stalled; no new item is taken until the last has left FIN. DIV runs the two
// 64-step restoring dividers (variance term and mean) side by side.
// Reset: rst_n asynchronous, active low; clears control and per-channel valid
// bits, so every channel reads as zero sum, mean and accumulator.
module running_mean_variance_accumulator_top #(
    parameter int CHANNELS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rmva_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rmva_pkg::out_t out_data
);

    rmva_pkg::cmd_t    cmd;
    rmva_pkg::status_t status;

    rmva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rmva_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== hdl/rmva_checker.sv =====
`include "running_mean_variance_accumulator_top_macros.svh"

module rmva_checker #(
    parameter int CHANNELS = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input rmva_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input rmva_pkg::out_t out_data
);

    `RMVA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
    `RMVA_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while an item is in progress")
    `RMVA_ASSERT_IMP(a_err_range, clk, rst_n, out_valid && out_data.error, 32'(out_data.channel_out) < 32'(CHANNELS), "error flagged on an out-of-range channel")
    `RMVA_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && (32'(out_data.channel_out) >= 32'(CHANNELS)), out_data.mean == '0 && out_data.variance_accum == '0, "out-of-range channel gave non-zero statistics")

    logic unused_in;
    assign unused_in = ^in_data;

endmodule

bind running_mean_variance_accumulator_top rmva_checker #(
    .CHANNELS (CHANNELS)
) u_rmva_checker (.*);
